>>> src/chained_hash_multiset_assert.svh
// Assertion macros for the chained hash multiset.
`ifndef CHAINED_HASH_MULTISET_ASSERT_SVH
`define CHAINED_HASH_MULTISET_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CHM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chm assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CHM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chm assertion failed");

`endif

>>> src/chm_pkg.sv
// Package: constants, codes and types of the chained hash multiset.
`timescale 1ns / 1ps
package chm_pkg;
    localparam int ENTRIES = 256;
    localparam int BUCKETS = 512;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int KEY_W   = 64;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int CNT_W   = IDX_W + 1;

    localparam logic [31:0]       GOLDEN_Q32 = 32'd2654435769;
    localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(ENTRIES);

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [BKT_W-1:0]  t_bucket;
endpackage

>>> src/chm_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface chm_req_if;
    import chm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    modport source (output valid, op, key, input ready);
    modport sink   (input valid, op, key, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] stored_count;
    modport source (output valid, status, stored_count, input ready);
    modport sink   (input valid, status, stored_count, output ready);
endinterface

>>> src/chained_hash_multiset.sv
// Top level: chained hash multiset sequencer over bucket, link, key and free-list RAMs.
// Insert: states RD, DEC, then FIN; INS2 comes before FIN when the chain already has a tail.
// Lookup and remove: RD, DEC, then WALK and CMP per entry until a hit or chain end, then FIN.
// Throughput: one item at a time; the chain walk (one key/link RAM read per entry) sets it.
// Reset: synchronous, active low; a clearing pass over all 512 buckets then nulls every head
// and tail, during which no item is accepted. Free list reads back its index until written.
`timescale 1ns / 1ps
module chained_hash_multiset (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp
);
    import chm_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_INS2 = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]              r_state, n_state;
    logic [BKT_W-1:0]        r_clr, n_clr;
    logic [OP_W-1:0]         r_op;
    logic signed [KEY_W-1:0] r_key;
    t_link                   r_cur, n_cur;
    t_link                   r_prev, n_prev;
    t_link                   r_tail, n_tail;
    logic [IDX_W-1:0]        r_e, n_e;
    logic [CNT_W-1:0]        r_free, n_free;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ST_W-1:0]         r_st, n_st;
    logic [ENTRIES-1:0]      r_fs_vld, n_fs_vld;
    logic                    r_fs_vld_q;
    logic                    r_ov, n_ov;
    logic [ST_W-1:0]         r_ostat, n_ostat;
    logic [CNT_W-1:0]        r_ocnt, n_ocnt;

    t_bucket          bucket;
    logic             accept;
    logic [IDX_W-1:0] fs_raddr;

    logic             hd_we, tl_we, key_we, nl_we, fs_we;
    t_bucket          hd_waddr, tl_waddr;
    t_link            hd_wdata, tl_wdata, hd_rdata, tl_rdata;
    logic [IDX_W-1:0] key_waddr, nl_waddr, fs_waddr;
    t_link            nl_wdata, nl_rdata;
    logic [KEY_W-1:0] key_rdata;
    logic [IDX_W-1:0] fs_wdata, fs_rdata;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign fs_raddr    = IDX_W'(r_free - CNT_W'(1));

    chm_hash u_hash (
        .i_clk    (i_clk),
        .i_en     (accept),
        .i_key    (i_req.key),
        .o_bucket (bucket)
    );

    chm_ram #(.W(LINK_W), .D(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(bucket), .o_rdata(hd_rdata)
    );
    chm_ram #(.W(LINK_W), .D(BUCKETS)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(bucket), .o_rdata(tl_rdata)
    );
    chm_ram #(.W(KEY_W), .D(ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(r_key),
        .i_raddr(r_cur[IDX_W-1:0]), .o_rdata(key_rdata)
    );
    chm_ram #(.W(LINK_W), .D(ENTRIES)) u_link (
        .i_clk(i_clk), .i_we(nl_we), .i_waddr(nl_waddr), .i_wdata(nl_wdata),
        .i_raddr(r_cur[IDX_W-1:0]), .o_rdata(nl_rdata)
    );
    chm_ram #(.W(IDX_W), .D(ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(fs_wdata),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );

    always_comb begin
        logic [IDX_W-1:0] e;
        logic             hit;
        n_state  = r_state;
        n_clr    = r_clr;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_tail   = r_tail;
        n_e      = r_e;
        n_free   = r_free;
        n_count  = r_count;
        n_st     = r_st;
        n_fs_vld = r_fs_vld;
        n_ov     = r_ov;
        n_ostat  = r_ostat;
        n_ocnt   = r_ocnt;
        hd_we = 1'b0; hd_waddr = bucket; hd_wdata = NIL_LINK;
        tl_we = 1'b0; tl_waddr = bucket; tl_wdata = NIL_LINK;
        key_we = 1'b0; key_waddr = '0;
        nl_we = 1'b0; nl_waddr = '0; nl_wdata = NIL_LINK;
        fs_we = 1'b0; fs_waddr = r_free[IDX_W-1:0]; fs_wdata = r_cur[IDX_W-1:0];
        e   = r_fs_vld_q ? fs_rdata : fs_raddr;
        hit = (key_rdata == r_key);

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                hd_we = 1'b1; hd_waddr = r_clr;
                tl_we = 1'b1; tl_waddr = r_clr;
                n_clr = r_clr + BKT_W'(1);
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                n_st    = ST_NOTFOUND;
                n_state = S_FIN;
                if (r_op == OP_INSERT) begin
                    if (r_free == '0) begin
                        n_st = ST_FULL;
                    end else begin
                        key_we = 1'b1; key_waddr = e;
                        nl_we = 1'b1; nl_waddr = e; nl_wdata = NIL_LINK;
                        tl_we = 1'b1; tl_wdata = {1'b0, e};
                        if (tl_rdata[IDX_W]) begin
                            hd_we = 1'b1; hd_wdata = {1'b0, e};
                        end else begin
                            n_state = S_INS2;
                        end
                        n_e     = e;
                        n_tail  = tl_rdata;
                        n_free  = r_free - CNT_W'(1);
                        n_count = r_count + CNT_W'(1);
                        n_st    = ST_DONE;
                    end
                end else if (r_op == OP_CONTAINS || r_op == OP_REMOVE) begin
                    n_cur   = hd_rdata;
                    n_prev  = NIL_LINK;
                    n_state = S_WALK;
                end
            end
            S_INS2: begin
                nl_we = 1'b1; nl_waddr = r_tail[IDX_W-1:0]; nl_wdata = {1'b0, r_e};
                n_state = S_FIN;
            end
            S_WALK: begin
                n_state = r_cur[IDX_W] ? S_FIN : S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_st    = ST_DONE;
                    n_state = S_FIN;
                    if (r_op == OP_REMOVE) begin
                        if (!r_prev[IDX_W]) begin
                            nl_we = 1'b1; nl_waddr = r_prev[IDX_W-1:0]; nl_wdata = nl_rdata;
                        end else begin
                            hd_we = 1'b1; hd_wdata = nl_rdata;
                        end
                        if (nl_rdata[IDX_W]) begin
                            tl_we = 1'b1; tl_wdata = r_prev;
                        end
                        if (r_free < FULL_CNT) begin
                            fs_we = 1'b1;
                            n_fs_vld[r_free[IDX_W-1:0]] = 1'b1;
                            n_free = r_free + CNT_W'(1);
                        end
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = nl_rdata;
                    n_state = S_WALK;
                end
            end
            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_ostat = r_st;
                    n_ocnt  = r_count;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_free   <= FULL_CNT;
            r_count  <= '0;
            r_fs_vld <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_free   <= n_free;
            r_count  <= n_count;
            r_fs_vld <= n_fs_vld;
            r_ov     <= n_ov;
        end
        if (accept) begin
            r_op  <= i_req.op;
            r_key <= i_req.key;
        end
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_tail     <= n_tail;
        r_e        <= n_e;
        r_st       <= n_st;
        r_ostat    <= n_ostat;
        r_ocnt     <= n_ocnt;
        r_fs_vld_q <= r_fs_vld[fs_raddr];
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.stored_count = r_ocnt;
endmodule

>>> src/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chm_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/chm_hash.sv
// Multiplicative hash: registered bucket index from the low key word.
`timescale 1ns / 1ps
module chm_hash (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [chm_pkg::KEY_W-1:0] i_key,
    output chm_pkg::t_bucket               o_bucket
);
    import chm_pkg::*;
    logic [63:0] prod;
    t_bucket     r_bucket;

    assign prod = 64'(i_key[31:0]) * 64'(GOLDEN_Q32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bucket <= prod[31:32-BKT_W];
        end
    end

    assign o_bucket = r_bucket;
endmodule

>>> src/chm_checker.sv
// Port-level checker for the chained hash multiset, bound to the top level.
`timescale 1ns / 1ps
`include "chained_hash_multiset_assert.svh"
module chm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [chm_pkg::ST_W-1:0]  i_status,
    input logic [chm_pkg::CNT_W-1:0] i_count
);
    import chm_pkg::*;

    `CHM_ASSERT_IMP(a_count_range, i_out_valid, i_count <= FULL_CNT)
    `CHM_ASSERT_IMP(a_status_code, i_out_valid, i_status != 2'd3)
    `CHM_ASSERT_IMP(a_full_only_when_full, i_out_valid && i_status == ST_FULL, i_count == FULL_CNT)
    `CHM_ASSERT_NXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_count))
endmodule

bind chained_hash_multiset chm_checker u_chm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_count     (o_rsp.stored_count)
);

>>> sim/tb_top.sv
// Testbench for the chained hash multiset: random and directed ops checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import chm_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] stored_count;
    } t_rsp;

    class multiset_scoreboard;
        logic [KEY_W-1:0] held[$];
        t_rsp             pending[$];
        int               mismatches;
        int               checked;

        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
            t_rsp r;
            int   idx[$];
            r.status = ST_NOTFOUND;
            case (op)
                OP_INSERT: begin
                    if (held.size() >= ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        held.push_back(key);
                        r.status = ST_DONE;
                    end
                end
                OP_CONTAINS: begin
                    idx = held.find_first_index(x) with (x == key);
                    if (idx.size() > 0) r.status = ST_DONE;
                end
                OP_REMOVE: begin
                    idx = held.find_first_index(x) with (x == key);
                    if (idx.size() > 0) begin
                        held.delete(idx[0]);
                        r.status = ST_DONE;
                    end
                end
                default: ;
            endcase
            r.stored_count = CNT_W'(held.size());
            pending.push_back(r);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d count=%0d",
                             got.status, got.stored_count);
                return;
            end
            want = pending.pop_front();
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status=%0d count=%0d, got status=%0d count=%0d",
                             want.status, want.stored_count, got.status, got.stored_count);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    chm_req_if req ();
    chm_rsp_if rsp ();

    chained_hash_multiset u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_rsp  (rsp.source)
    );

    multiset_scoreboard sb;
    logic [KEY_W-1:0]   pool[$];
    int                 n_ins, n_con, n_rem, n_full;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, bit gaps);
        int g;
        g = 0;
        if (gaps) g = gap_len();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= key;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(op, key);
        case (op)
            OP_INSERT:   n_ins++;
            OP_CONTAINS: n_con++;
            OP_REMOVE:   n_rem++;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // response side: random stalls, sample at rising edge
    initial begin
        int g;
        rsp.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if ($urandom_range(3) == 0) g = 0;
            if (g > 0) begin
                rsp.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
            sb.check_response({rsp.status, rsp.stored_count});
        end
    end

    initial begin
        logic [KEY_W-1:0] k;
        logic [OP_W-1:0]  op;
        int               p;
        sb = new();
        req.valid = 1'b0;
        req.op    = OP_INSERT;
        req.key   = '0;
        i_rst_n   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, duplicates, negative keys, unused op, misses
        send_item(OP_CONTAINS, 64'h0, 0);
        send_item(OP_REMOVE, 64'h0, 0);
        send_item(OP_INSERT, 64'h0, 0);
        send_item(OP_INSERT, 64'h0, 0);
        send_item(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, 0);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_CONTAINS, 64'h8000_0000_0000_0000, 0);
        send_item(OP_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFE, 0);
        send_item(OP_REMOVE, 64'h0, 0);
        send_item(OP_CONTAINS, 64'h0, 0);
        send_item(OP_REMOVE, 64'h0, 0);
        send_item(OP_REMOVE, 64'h0, 0);
        send_item(2'd3, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_item(OP_REMOVE, 64'h8000_0000_0000_0000, 0);
        drain();

        // fill to full, with colliding keys (multiples of 2^32 share a bucket)
        for (int i = 0; i < ENTRIES + 3; i++) begin
            k = (i < 24) ? {32'(i), 32'h0} : rand_key();
            if (i < 8) k = 64'h1234;
            pool.push_back(k);
            send_item(OP_INSERT, k, $urandom_range(3) == 0);
            if (i >= ENTRIES) n_full++;
        end
        for (int i = 0; i < 40; i++)
            send_item($urandom_range(1) ? OP_CONTAINS : OP_REMOVE,
                      pool[$urandom_range(pool.size() - 1)], 1);
        drain();

        // random mix around a key pool; swings load up and down
        for (int i = 0; i < 1500; i++) begin
            p = $urandom_range(99);
            if ((i / 300) % 2 == 0) op = (p < 55) ? OP_INSERT : (p < 75) ? OP_CONTAINS : OP_REMOVE;
            else                    op = (p < 25) ? OP_INSERT : (p < 50) ? OP_CONTAINS : OP_REMOVE;
            if (p == 99) op = 2'd3;
            if (pool.size() > 0 && $urandom_range(99) < 70)
                k = pool[$urandom_range(pool.size() - 1)];
            else if ($urandom_range(9) == 0)
                k = {32'($urandom_range(15)), 32'h0};
            else
                k = rand_key();
            if (op == OP_INSERT) pool.push_back(k);
            if (pool.size() > 400) pool.delete(0);
            if (op == OP_INSERT && sb.held.size() >= ENTRIES) n_full++;
            send_item(op, k, i % 200 < 150);
            if (i == 700) drain();
        end
        drain();
        repeat (50) @(negedge i_clk);
        $display("covered %0d inserts (%0d against a full table), %0d lookups, %0d removes",
                 n_ins, n_full, n_con, n_rem);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout");
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/chm_pkg.sv
src/chm_if.sv
src/chm_ram.sv
src/chm_hash.sv
src/chained_hash_multiset.sv
src/chm_checker.sv
sim/tb_top.sv
